// ===== src/edf_tick_scheduler_unit_assert.svh =====
// Assertion macros for the EDF tick scheduler, sampled on clk and disabled during reset.
`ifndef EDF_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define EDF_TICK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EDF_TSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define EDF_TSU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/edfts_pkg.sv =====
// Shared types and constants of the EDF tick scheduler.
package edfts_pkg;

	localparam int unsigned SLOT_W   = 3;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned MASK_W   = 8;
	localparam int unsigned SLOT_LIM = 8;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_TICK = 1'b1;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic              load_en;
		logic [SLOT_W-1:0] load_slot;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] burst;
		logic              scan_en;
		logic              update_en;
		logic              pick_valid;
	} cell_ctrl_t;

endpackage

// ===== src/edfts_cell.sv =====
// One task cell: holds a task's timing state and forwards the running best candidate.
module edfts_cell #(
	parameter int TASK_COUNT = 8,
	parameter int CELL_INDEX = 0,
	localparam int IDX_W = $clog2(TASK_COUNT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  edfts_pkg::cell_ctrl_t          ctrl,
	input  logic [IDX_W-1:0]               step,
	input  logic [IDX_W-1:0]               pick_idx,
	input  logic                           prev_valid,
	input  logic [IDX_W-1:0]               prev_idx,
	input  logic [edfts_pkg::TICK_W-1:0]   prev_dl,
	output logic                           best_valid,
	output logic [IDX_W-1:0]               best_idx,
	output logic [edfts_pkg::TICK_W-1:0]   best_dl,
	output logic                           done,
	output logic                           miss
);
	import edfts_pkg::*;

	logic [TICK_W-1:0] period_q;
	logic [TICK_W-1:0] burst_q;
	logic [TICK_W-1:0] dl_q;
	logic [TICK_W-1:0] work_q;
	logic              armed_q;

	logic              load_hit;
	logic              scan_hit;
	logic              ready;
	logic              take;
	logic              is_pick;
	logic [TICK_W-1:0] work_after;
	logic [TICK_W-1:0] dl_dec;
	logic              expire;

	assign load_hit = ctrl.load_en && (CELL_INDEX < SLOT_LIM)
		&& (ctrl.load_slot == SLOT_W'(CELL_INDEX));
	assign scan_hit = ctrl.scan_en && (step == IDX_W'(CELL_INDEX));

	// Strict less-than keeps the lower index on a tie.
	assign ready = armed_q && (work_q != '0);
	assign take  = ready && (!prev_valid || (dl_q < prev_dl));

	assign is_pick    = ctrl.pick_valid && (pick_idx == IDX_W'(CELL_INDEX));
	assign work_after = is_pick ? (work_q - TICK_W'(1)) : work_q;
	assign dl_dec     = dl_q - TICK_W'(1);
	assign expire     = armed_q && (dl_dec == '0);
	assign miss       = expire && (work_after != '0);
	assign done       = is_pick && (work_after == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			burst_q  <= '0;
			dl_q     <= '0;
			work_q   <= '0;
			armed_q  <= 1'b0;
		end else if (load_hit) begin
			period_q <= ctrl.period;
			burst_q  <= ctrl.burst;
			dl_q     <= ctrl.period;
			work_q   <= ctrl.burst;
			armed_q  <= (ctrl.period != '0);
		end else if (ctrl.update_en && armed_q) begin
			if (expire) begin
				dl_q   <= period_q;
				work_q <= burst_q;
			end else begin
				dl_q   <= dl_dec;
				work_q <= work_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid <= 1'b0;
		end else if (scan_hit) begin
			best_valid <= prev_valid || take;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_hit) begin
			best_idx <= take ? IDX_W'(CELL_INDEX) : prev_idx;
			best_dl  <= take ? dl_q : prev_dl;
		end
	end

endmodule

// ===== src/edf_tick_scheduler_unit.sv =====
// Top level of the earliest-deadline-first tick scheduler: sequencer and cell chain.
//
// Usage: every transfer on the s_ channel is one item. s_tuser is the action:
// a load writes one task's period and burst, arms the task when the period is
// nonzero and restarts its deadline and work counters; a tick advances the
// scheduler by one tick. Every item returns exactly one transfer on the m_
// channel with the running task, the idle flag, the job-done flag and the
// mask of tasks that missed their deadline in this tick (all idle for loads).
// The tasks live in a chain of TASK_COUNT cells. A tick scans the chain one
// cell per cycle, each cell passing the best candidate so far to its
// neighbor, then updates every cell in parallel in the update state.
// A load goes to the emit state and then into the output register; a tick
// goes through the scan, update and emit states on its way there.
// The next item is taken once the result is parked in the output register,
// so the block takes no new item while the last one is still being worked on.
// Reset disarms all tasks and clears all counters. When the receiver stalls,
// one finished result waits in the output register while the next item is
// worked on; the block then waits to hand over that second result.
module edf_tick_scheduler_unit #(
	parameter int TASK_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [2:0] task_slot, [18:3] period_ticks, [34:19] burst_ticks
	input  logic        s_tuser,  // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [2:0] running_task, [3] idle, [4] job_done, [12:5] missed_mask
);
	import edfts_pkg::*;

	localparam int IDX_W = $clog2(TASK_COUNT);
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TASK_COUNT - 1);
	localparam logic [MASK_W-1:0] MASK_VALID = MASK_W'((64'd1 << TASK_COUNT) - 64'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  step_q;
	logic [2:0]        res_task_q;
	logic              res_idle_q;
	logic              res_done_q;
	logic [MASK_W-1:0] res_mask_q;
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	cell_ctrl_t        ctrl;
	logic              in_fire;
	logic              out_free;

	// Candidate chain: entry i feeds cell i, entry TASK_COUNT is the final pick.
	logic              chain_valid [TASK_COUNT+1];
	logic [IDX_W-1:0]  chain_idx   [TASK_COUNT+1];
	logic [TICK_W-1:0] chain_dl    [TASK_COUNT+1];
	logic [TASK_COUNT-1:0] done_vec;
	logic [TASK_COUNT-1:0] miss_vec;

	logic [31:0]       miss_ext;
	logic [7:0]        pick_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign ctrl.load_en    = in_fire && (s_tuser == ACTION_LOAD);
	assign ctrl.load_slot  = s_tdata[2:0];
	assign ctrl.period     = s_tdata[18:3];
	assign ctrl.burst      = s_tdata[34:19];
	assign ctrl.scan_en    = (state_q == ST_SCAN);
	assign ctrl.update_en  = (state_q == ST_UPDATE);
	assign ctrl.pick_valid = chain_valid[TASK_COUNT];

	// The head of the chain sees no candidate yet.
	assign chain_valid[0] = 1'b0;
	assign chain_idx[0]   = '0;
	assign chain_dl[0]    = '0;

	for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
		edfts_cell #(
			.TASK_COUNT (TASK_COUNT),
			.CELL_INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.step       (step_q),
			.pick_idx   (chain_idx[TASK_COUNT]),
			.prev_valid (chain_valid[i]),
			.prev_idx   (chain_idx[i]),
			.prev_dl    (chain_dl[i]),
			.best_valid (chain_valid[i+1]),
			.best_idx   (chain_idx[i+1]),
			.best_dl    (chain_dl[i+1]),
			.done       (done_vec[i]),
			.miss       (miss_vec[i])
		);
	end

	// Only the first eight tasks are reported; narrower task counts leave zeros.
	assign miss_ext = 32'(miss_vec);
	assign pick_ext = 8'(chain_idx[TASK_COUNT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_valid_q  <= 1'b0;
			m_data_q   <= '0;
			res_task_q <= '0;
			res_idle_q <= 1'b0;
			res_done_q <= 1'b0;
			res_mask_q <= '0;
		end else begin
			// In the emit state the output register is reloaded below instead.
			if (m_valid_q && m_tready && (state_q != ST_EMIT)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == ACTION_TICK) begin
							step_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							res_task_q <= '0;
							res_idle_q <= 1'b1;
							res_done_q <= 1'b0;
							res_mask_q <= '0;
							state_q    <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_UPDATE;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				ST_UPDATE: begin
					res_task_q <= chain_valid[TASK_COUNT] ? pick_ext[2:0] : 3'd0;
					res_idle_q <= !chain_valid[TASK_COUNT];
					res_done_q <= |done_vec;
					res_mask_q <= miss_ext[MASK_W-1:0];
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {3'd0, res_mask_q, res_done_q, res_idle_q, res_task_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "edf_tick_scheduler_unit_assert.svh"

	// An idle result never names a task or reports a finished job.
	`EDF_TSU_ASSERT_IMP(a_idle_quiet, m_tvalid && m_tdata[3], (m_tdata[2:0] == 3'd0) && !m_tdata[4], "idle result carries a task")
	// No task beyond the configured count can ever miss.
	`EDF_TSU_ASSERT_IMP(a_mask_range, m_tvalid, (m_tdata[12:5] & ~MASK_VALID) == '0, "miss reported for absent task")
	// The update cycle always hands its result to the output stage next.
	`EDF_TSU_ASSERT_NXT(a_update_emit, state_q == ST_UPDATE, state_q == ST_EMIT, "update not followed by emit")

endmodule
